>>> hw/rtl/segmented_argmax_macros.svh
// Assertion macros for the segmented argmax block.
`ifndef SEGMENTED_ARGMAX_MACROS_SVH
`define SEGMENTED_ARGMAX_MACROS_SVH
`ifndef ASSERT_OFF
`define SA_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SA_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SA_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SA_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> hw/rtl/sa_pkg.sv
package sa_pkg;
  localparam int IndexWidth = 32;
  localparam int OutWidth = IndexWidth + 1;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    TYPE_F32 = 2'd0,
    TYPE_F64 = 2'd1,
    TYPE_I32 = 2'd2,
    TYPE_I64 = 2'd3
  } elem_type_t;

  typedef struct packed {
    logic [63:0] value_bits;
    logic has_value;
    logic last_in_segment;
    logic [IndexWidth-1:0] index;
  } work_item_t;

  // Map a float to an unsigned key whose order is the float order.
  function automatic logic [63:0] f64_key(input logic [63:0] v);
    f64_key = v[63] ? ~v : (v | 64'h8000_0000_0000_0000);
  endfunction

  function automatic logic [31:0] f32_key(input logic [31:0] v);
    f32_key = v[31] ? ~v : (v | 32'h8000_0000);
  endfunction

  function automatic logic is_nan64(input logic [63:0] v);
    is_nan64 = (v[62:52] == 11'h7ff) && (v[51:0] != 52'd0);
  endfunction

  function automatic logic is_nan32(input logic [31:0] v);
    is_nan32 = (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic is_zero64(input logic [63:0] v);
    is_zero64 = (v[62:0] == 63'd0);
  endfunction

  function automatic logic is_zero32(input logic [31:0] v);
    is_zero32 = (v[30:0] == 31'd0);
  endfunction

  // True when a is strictly greater than b under type t.
  function automatic logic greater(input logic [63:0] a, input logic [63:0] b,
                                   input elem_type_t t);
    logic r;
    r = 1'b0;
    case (t)
      TYPE_F32: begin
        if (is_nan32(a[31:0]) || is_nan32(b[31:0])) r = 1'b0;
        else if (is_zero32(a[31:0]) && is_zero32(b[31:0])) r = 1'b0;
        else r = f32_key(a[31:0]) > f32_key(b[31:0]);
      end
      TYPE_F64: begin
        if (is_nan64(a) || is_nan64(b)) r = 1'b0;
        else if (is_zero64(a) && is_zero64(b)) r = 1'b0;
        else r = f64_key(a) > f64_key(b);
      end
      TYPE_I32: r = $signed(a[31:0]) > $signed(b[31:0]);
      TYPE_I64: r = $signed(a) > $signed(b);
      default: r = 1'b0;
    endcase
    greater = r;
  endfunction
endpackage

>>> hw/rtl/sa_if.sv
interface sa_in_if import sa_pkg::*; ();
  logic valid;
  logic ready;
  logic [63:0] value_bits;
  logic has_value;
  logic last_in_segment;
  modport source(output valid, value_bits, has_value, last_in_segment, input ready);
  modport sink(input valid, value_bits, has_value, last_in_segment, output ready);
endinterface

interface sa_out_if import sa_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [OutWidth-1:0] best_index;
  modport source(output valid, best_index, input ready);
  modport sink(input valid, best_index, output ready);
endinterface

interface sa_cfg_if ();
  logic valid;
  logic ready;
  logic [1:0] element_type;
  modport source(output valid, element_type, input ready);
  modport sink(input valid, element_type, output ready);
endinterface

>>> hw/rtl/sa_front.sv
module sa_front import sa_pkg::*; (
  input  logic clk,
  input  logic rst,
  sa_in_if.sink in,
  output logic push,
  output work_item_t item,
  input  logic full
);
  logic [IndexWidth-1:0] element_count;

  assign in.ready = !full;
  assign push = in.valid && !full;
  assign item.value_bits = in.value_bits;
  assign item.has_value = in.has_value;
  assign item.last_in_segment = in.last_in_segment;
  assign item.index = element_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (push && in.has_value && (element_count != {IndexWidth{1'b1}})) begin
      element_count <= element_count + 1'b1;
    end
  end
endmodule

>>> hw/rtl/sa_queue.sv
module sa_queue import sa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  work_item_t push_item,
  output logic full,
  output logic nonempty,
  input  logic pop,
  output work_item_t head
);
  localparam int PtrW = $clog2(QueueDepth);
  work_item_t mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0] count;

  assign full = (count == (PtrW+1)'(QueueDepth));
  assign nonempty = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

>>> hw/rtl/sa_back.sv
module sa_back import sa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  elem_type_t elem_type,
  input  logic nonempty,
  input  work_item_t head,
  output logic pop,
  sa_out_if.source out
);
  logic [63:0] best_value;
  logic [IndexWidth-1:0] best_position;
  logic segment_nonempty;
  logic take;
  logic [IndexWidth-1:0] pos_now;
  logic open_now;

  assign pop = nonempty && (!out.valid || out.ready || !head.last_in_segment);
  assign take = head.has_value &&
                (!segment_nonempty || greater(head.value_bits, best_value, elem_type));
  assign pos_now = take ? head.index : best_position;
  assign open_now = segment_nonempty || head.has_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_nonempty <= 1'b0;
      best_value <= '0;
      best_position <= '0;
      out.valid <= 1'b0;
    end else begin
      if (out.valid && out.ready) out.valid <= 1'b0;
      if (pop) begin
        if (take) begin
          best_value <= head.value_bits;
          best_position <= head.index;
        end
        segment_nonempty <= open_now && !head.last_in_segment;
        if (head.last_in_segment) out.valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last_in_segment) begin
      out.best_index <= open_now ? {1'b0, pos_now} : {OutWidth{1'b1}};
    end
  end
endmodule

>>> hw/rtl/segmented_argmax.sv
// Streaming argmax over segments: one request per cycle is accepted unless the
// queue is full, and each request closing a segment yields the absolute index
// of its first maximum (or -1 when empty) via the queue and output register.
// The element compare in the back end sets the one-request-per-cycle rate; a
// two-entry queue decouples the front counter from the compare stage and the
// output register. element_type may only be written while the block is idle.
`include "segmented_argmax_macros.svh"
module segmented_argmax import sa_pkg::*; (
  input  logic clk,
  input  logic rst,
  sa_cfg_if.sink cfg,
  sa_in_if.sink in,
  sa_out_if.source out
);
  elem_type_t elem_type;
  logic push;
  logic full;
  logic nonempty;
  logic pop;
  work_item_t push_item;
  work_item_t head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_type <= TYPE_F32;
    end else if (cfg.valid) begin
      elem_type <= elem_type_t'(cfg.element_type);
    end
  end

  sa_front u_front (.clk, .rst, .in, .push, .item(push_item), .full);
  sa_queue u_queue (.clk, .rst, .push, .push_item, .full, .nonempty, .pop, .head);
  sa_back u_back (.clk, .rst, .elem_type, .nonempty, .head, .pop, .out);

  `SA_ASSERT_IMPL(a_no_pop_empty, clk, rst, pop |-> nonempty, "pop from empty queue")
  `SA_ASSERT_IMPL(a_no_push_full, clk, rst, push |-> !full, "push into full queue")
  `SA_ASSERT_IMPL(a_out_hold, clk, rst, out.valid && !out.ready |=> out.valid && $stable(out.best_index), "result dropped")
endmodule

>>> sim/tb_top.sv
module tb_top;
  import sa_pkg::*;

  logic clk;
  logic rst;

  sa_cfg_if cfg_ch ();
  sa_in_if in_ch ();
  sa_out_if out_ch ();

  segmented_argmax u_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch.sink),
    .in(in_ch.sink),
    .out(out_ch.source)
  );

  localparam logic [IndexWidth-1:0] IdxMax = {IndexWidth{1'b1}};
  localparam logic signed [OutWidth-1:0] EmptyIndex = -1;
  localparam int StallLimit = 2000;

  elem_type_t cur_type;
  logic [63:0] top_value;
  logic [IndexWidth-1:0] top_position;
  logic seg_open;
  logic [IndexWidth-1:0] next_index;

  logic signed [OutWidth-1:0] index_queue[$];
  int errors;
  int idle_cycles;
  bit idling_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] order_key(input logic [63:0] v, input elem_type_t t);
    case (t)
      TYPE_F32: order_key = {32'd0, v[31] ? ~v[31:0] : (v[31:0] | 32'h8000_0000)};
      TYPE_F64: order_key = v[63] ? ~v : (v | 64'h8000_0000_0000_0000);
      TYPE_I32: order_key = {32'd0, v[31:0] ^ 32'h8000_0000};
      default: order_key = v ^ 64'h8000_0000_0000_0000;
    endcase
  endfunction

  function automatic bit beats_top(input logic [63:0] a, input logic [63:0] b,
                                   input elem_type_t t);
    bit a_nan;
    bit b_nan;
    bit both_zero;
    a_nan = 0;
    b_nan = 0;
    both_zero = 0;
    if (t == TYPE_F32) begin
      a_nan = (a[30:23] == 8'hff) && (a[22:0] != 0);
      b_nan = (b[30:23] == 8'hff) && (b[22:0] != 0);
      both_zero = (a[30:0] == 0) && (b[30:0] == 0);
    end else if (t == TYPE_F64) begin
      a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 0);
      b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 0);
      both_zero = (a[62:0] == 0) && (b[62:0] == 0);
    end
    if (a_nan || b_nan || both_zero) return 0;
    return order_key(a, t) > order_key(b, t);
  endfunction

  task automatic predict_argmax(input logic [63:0] v, input bit has, input bit last);
    if (has) begin
      if (!seg_open || beats_top(v, top_value, cur_type)) begin
        top_value = v;
        top_position = next_index;
        seg_open = 1;
      end
      if (next_index != IdxMax) next_index = next_index + 1;
    end
    if (last) begin
      index_queue.push_back(seg_open ? $signed({1'b0, top_position}) : EmptyIndex);
      seg_open = 0;
    end
  endtask

  task automatic random_gap();
    int n;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_element(input logic [63:0] v, input bit has, input bit last);
    random_gap();
    in_ch.valid <= 1'b1;
    in_ch.value_bits <= v;
    in_ch.has_value <= has;
    in_ch.last_in_segment <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_argmax(v, has, last);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (index_queue.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_type(input elem_type_t t);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.element_type <= t;
    do @(posedge clk); while (!cfg_ch.ready);
    cur_type = t;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [63:0] random_value(input elem_type_t t);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = 64'h0;
      1: v = 64'h8000_0000_0000_0000;
      2: v = (t == TYPE_F64) ? 64'h7ff8_0000_0000_0001 : {v[63:32], 32'h7fc0_0001};
      3: v = (t == TYPE_F64) ? 64'hfff0_0000_0000_0000 : {v[63:32], 32'hff80_0000};
      4: v = {v[63:32], 32'h8000_0000};
      5: v = {v[63:4], 4'h0} & 64'h0000_0000_0000_00f0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    write_type(TYPE_I64);
    send_element(64'h0, 1'b0, 1'b1);
    send_element(64'h0, 1'b0, 1'b0);
    send_element(64'h7fff_ffff_ffff_ffff, 1'b1, 1'b0);
    send_element(64'h8000_0000_0000_0000, 1'b1, 1'b0);
    send_element(64'h7fff_ffff_ffff_ffff, 1'b1, 1'b1);
    send_element(64'hffff_ffff_ffff_ffff, 1'b1, 1'b1);
    write_type(TYPE_I32);
    send_element(64'hffff_ffff_8000_0000, 1'b1, 1'b0);
    send_element(64'h0000_0000_7fff_ffff, 1'b1, 1'b0);
    send_element(64'h0, 1'b0, 1'b1);
    write_type(TYPE_F32);
    send_element(64'h0000_0000_7fc0_0000, 1'b1, 1'b0);
    send_element(64'h0000_0000_7f80_0000, 1'b1, 1'b1);
    send_element(64'h0000_0000_8000_0000, 1'b1, 1'b0);
    send_element(64'h0000_0000_0000_0000, 1'b1, 1'b0);
    send_element(64'h0000_0000_ff80_0000, 1'b1, 1'b1);
    write_type(TYPE_F64);
    send_element(64'hbff0_0000_0000_0000, 1'b1, 1'b0);
    send_element(64'h7ff0_0000_0000_0001, 1'b1, 1'b0);
    send_element(64'h3ff0_0000_0000_0000, 1'b1, 1'b0);
    send_element(64'h8000_0000_0000_0000, 1'b1, 1'b1);
    send_element(64'h3ff0_0000_0000_0000, 1'b1, 1'b0);
    write_type(TYPE_I64);
    send_element(64'h0000_0000_0000_0001, 1'b1, 1'b1);
  endtask

  task automatic test_random_segments(input int count);
    int sent;
    int len;
    elem_type_t t;
    sent = 0;
    while (sent < count) begin
      t = elem_type_t'($urandom_range(0, 3));
      if (t != cur_type && $urandom_range(0, 3) == 0) write_type(t);
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        send_element(random_value(cur_type), $urandom_range(0, 7) != 0,
                     (i == len - 1) || ($urandom_range(0, 15) == 0));
        sent++;
      end
      if (len == 0) begin
        send_element({$urandom, $urandom}, 1'b0, 1'b1);
        sent++;
      end
    end
  endtask

  task automatic test_pause_until_drained();
    send_element(64'h5, 1'b1, 1'b0);
    drain_results();
    send_element(64'h6, 1'b1, 1'b1);
  endtask

  initial begin : check_results
    logic signed [OutWidth-1:0] want;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (index_queue.size() == 0) begin
          $display("%0t: unexpected result, actual %0d", $time, out_ch.best_index);
          errors++;
        end else begin
          want = index_queue.pop_front();
          if (out_ch.best_index !== want) begin
            $display("%0t: best_index expected %0d actual %0d", $time, want,
                     out_ch.best_index);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || !idling_on) begin
      out_ch.ready <= 1'b1;
    end else if (out_ch.ready && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
    end else if (!out_ch.ready && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    idling_on = 1;
    rst = 1'b1;
    cur_type = TYPE_F32;
    top_value = 0;
    top_position = 0;
    seg_open = 0;
    next_index = 0;
    in_ch.valid = 1'b0;
    in_ch.value_bits = 64'h0;
    in_ch.has_value = 1'b0;
    in_ch.last_in_segment = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.element_type = TYPE_F32;
    out_ch.ready = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pause_until_drained();
    test_random_segments(450);
    idling_on = 0;
    test_random_segments(80);
    drain_results();
    if (errors == 0 && index_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> segmented_argmax.f
+incdir+hw/rtl
hw/rtl/sa_pkg.sv
hw/rtl/sa_if.sv
hw/rtl/sa_front.sv
hw/rtl/sa_queue.sv
hw/rtl/sa_back.sv
hw/rtl/segmented_argmax.sv
sim/tb_top.sv
